[hdl/clr_pkg.sv]
// Shared types and codes for the consensus log reconciler.
// Used by the top level; no dependencies.
`default_nettype none
package clr_pkg;

  localparam int LogDepthDefault      = 1024;
  localparam int MaxEntryBytesDefault = 4096;
  localparam logic [10:0] MaxEntriesReset = 11'd1024;

  localparam logic [2:0] OP_APPEND  = 3'd0;
  localparam logic [2:0] OP_COMPACT = 3'd1;
  localparam logic [2:0] OP_START   = 3'd2;
  localparam logic [2:0] OP_ENTRY   = 3'd3;
  localparam logic [2:0] OP_READ    = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVAL   = 2'd1;
  localparam logic [1:0] ST_PROTO   = 2'd2;
  localparam logic [1:0] ST_NOSPACE = 2'd3;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_COMPARE = 2'd1;
  localparam logic [1:0] PH_WRITE   = 2'd2;

  localparam logic [1:0] REG_MAX_ENTRIES = 2'd0;
  localparam logic [1:0] REG_START_INDEX = 2'd1;
  localparam logic [1:0] REG_START_TERM  = 2'd2;

  typedef struct packed {
    logic [63:0] tag;
    logic [12:0] len;
    logic [63:0] cmd;
    logic [63:0] term;
  } entry_t;

  typedef struct packed {
    logic [3:0]  pad;
    logic [10:0] entry_count;
    logic [63:0] guard_index;
    logic        config_ok;
    logic [63:0] payload_tag;
    logic [12:0] byte_count;
    logic [63:0] cmd_ident;
    logic [63:0] term;
    logic [63:0] index;
    logic [2:0]  operation;
  } item_t;

  typedef struct packed {
    logic [3:0]  pad;
    logic [63:0] log_last_term;
    logic [63:0] log_last_index;
    logic [63:0] entry_tag;
    logic [12:0] entry_length;
    logic [63:0] entry_command;
    logic [63:0] entry_term;
    logic [10:0] write_count;
    logic [63:0] cut_index;
    logic        changed;
    logic        matched;
    logic [63:0] result_index;
    logic [1:0]  status;
  } result_t;

endpackage
`default_nettype wire

[hdl/clr_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module clr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

[hdl/consensus_log_reconciler.sv]
// Consensus log reconciler: a bounded log whose entry metadata lives in one
// RAM (clr_ram); depends on clr_pkg. Each item passes three steps (accept,
// RAM read, execute and write back) through the single read port of the entry
// RAM. A reconcile start whose previous term mismatches walks back over
// earlier entries of that term, reading then comparing each one. The result
// sits in an output register, so the next request is accepted while it waits.
`default_nettype none
module consensus_log_reconciler #(
  parameter int LOG_DEPTH       = clr_pkg::LogDepthDefault,
  parameter int MAX_ENTRY_BYTES = clr_pkg::MaxEntryBytesDefault
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // operation, index, term, cmd_ident, byte_count, payload_tag, config_ok,
  // guard_index, entry_count, zero pad
  input  wire logic [351:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // status, result_index, matched, changed, cut_index, write_count,
  // entry_term, entry_command, entry_length, entry_tag, log_last_index,
  // log_last_term, zero pad
  output logic      [479:0] m_axis_tdata,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic   [1:0] cfg_index_i,
  input  wire logic  [63:0] cfg_data_i
);

  localparam int AW    = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int CW0   = $clog2(LOG_DEPTH + 1);
  localparam int CNT_W = (CW0 > 11) ? CW0 : 11;
  localparam int LEN_W = 18;
  localparam int EW    = $bits(clr_pkg::entry_t);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_WREQ = 3'd3;
  localparam logic [2:0] S_WCMP = 3'd4;

  localparam logic [1:0] REG_IDX_MAX   = clr_pkg::REG_MAX_ENTRIES;
  localparam logic [1:0] REG_IDX_SIDX  = clr_pkg::REG_START_INDEX;
  localparam logic [1:0] REG_IDX_STERM = clr_pkg::REG_START_TERM;

  logic [2:0]       state_q, state_d;
  clr_pkg::item_t   item_q;
  logic [10:0]      max_q, max_d;
  logic [63:0]      sidx_q, sidx_d, sterm_q, sterm_d;
  logic [63:0]      base_q, base_d, bterm_q, bterm_d, last_q, last_d, lterm_q, lterm_d;
  logic [CNT_W-1:0] held_q, held_d;
  logic [AW-1:0]    head_q, head_d;
  logic [1:0]       phase_q, phase_d;
  logic [10:0]      rem_q, rem_d, acnt_q, acnt_d;
  logic [63:0]      exp_q, exp_d, protr_q, protr_d, wfrom_q, wfrom_d;
  logic [CNT_W-1:0] roff_q, roff_d;
  logic             trunc_q, trunc_d;
  logic [CNT_W-1:0] off_q, off_d;
  logic [AW-1:0]    slot_q, slot_d;
  logic             inr_q, inr_d, exists_q, exists_d;
  logic [63:0]      ct_q, ct_d;
  logic [CNT_W-1:0] woff_q, woff_d;
  logic [AW-1:0]    wslot_q, wslot_d, wslot_dec;

  logic             out_valid_q, out_valid_d, out_ld, out_free;
  clr_pkg::result_t out_q, res;

  logic             ram_re, ram_we;
  logic [AW-1:0]    ram_raddr;
  logic [EW-1:0]    ram_rdata;
  clr_pkg::entry_t  ent, wr_ent;

  logic [63:0]      off64;
  logic [CNT_W-1:0] offsel, cap;
  logic             inr, len_big, wr, fin, eq;
  logic [63:0]      wfrom_nx;
  logic             trunc_nx;
  logic [10:0]      nm;
  logic [63:0]      nsi, nst;
  logic             init_ok;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h,
                                            input logic [CNT_W-1:0] o);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(h) + (CNT_W+1)'(o);
    if (s >= (CNT_W+1)'(LOG_DEPTH)) begin
      s = s - (CNT_W+1)'(LOG_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  clr_ram #(.WIDTH(EW), .DEPTH(LOG_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (wr_ent),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ent           = clr_pkg::entry_t'(ram_rdata);
  assign wr_ent        = '{tag: item_q.payload_tag, len: item_q.byte_count,
                           cmd: item_q.cmd_ident, term: item_q.term};
  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign off64   = item_q.index - base_q - 64'd1;
  assign inr     = (item_q.index > base_q) && (item_q.index <= last_q);
  assign cap     = ((CNT_W)'(max_q) > (CNT_W)'(LOG_DEPTH)) ? (CNT_W)'(LOG_DEPTH)
                                                           : (CNT_W)'(max_q);
  assign len_big = (LEN_W)'(item_q.byte_count) > (LEN_W)'(MAX_ENTRY_BYTES);
  assign wslot_dec = (wslot_q == '0) ? (AW)'(LOG_DEPTH - 1) : wslot_q - 1'b1;
  assign eq      = (ent.term == ct_q);

  always_comb begin
    unique case (item_q.operation)
      clr_pkg::OP_APPEND: offsel = held_q;
      clr_pkg::OP_ENTRY:  offsel = roff_q;
      default:            offsel = off64[CNT_W-1:0];
    endcase
  end

  always_comb begin
    state_d = state_q;
    base_d = base_q; bterm_d = bterm_q; last_d = last_q; lterm_d = lterm_q;
    held_d = held_q; head_d = head_q; phase_d = phase_q;
    rem_d = rem_q; acnt_d = acnt_q; exp_d = exp_q; protr_d = protr_q;
    wfrom_d = wfrom_q; roff_d = roff_q; trunc_d = trunc_q;
    off_d = off_q; slot_d = slot_q; inr_d = inr_q; exists_d = exists_q;
    ct_d = ct_q; woff_d = woff_q; wslot_d = wslot_q;
    max_d = max_q; sidx_d = sidx_q; sterm_d = sterm_q;
    res = '0;
    out_ld = 1'b0;
    ram_re = 1'b0;
    ram_we = 1'b0;
    ram_raddr = slot_of(head_q, offsel);
    wr = 1'b0;
    fin = 1'b0;
    wfrom_nx = wfrom_q;
    trunc_nx = trunc_q;
    nm = max_q; nsi = sidx_q; nst = sterm_q;
    init_ok = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        off_d    = offsel;
        slot_d   = slot_of(head_q, offsel);
        inr_d    = inr;
        exists_d = roff_q < held_q;
        ram_re   = 1'b1;
        state_d  = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          out_ld  = 1'b1;
          state_d = S_IDLE;
          if (item_q.operation != clr_pkg::OP_ENTRY &&
              item_q.operation <= clr_pkg::OP_READ) begin
            phase_d = clr_pkg::PH_IDLE;
          end
          unique case (item_q.operation)
            clr_pkg::OP_APPEND: begin
              if (item_q.term == '0 || item_q.cmd_ident == '0) begin
                res.status = clr_pkg::ST_INVAL;
              end else if (len_big || held_q >= cap || last_q == '1) begin
                res.status = clr_pkg::ST_NOSPACE;
              end else begin
                ram_we = 1'b1;
                held_d = held_q + 1'b1;
                last_d = last_q + 64'd1;
                lterm_d = item_q.term;
                res.result_index = last_q + 64'd1;
              end
            end
            clr_pkg::OP_COMPACT: begin
              if (!inr_q || item_q.term == '0) begin
                res.status = clr_pkg::ST_INVAL;
              end else if (ent.term != item_q.term) begin
                res.status = clr_pkg::ST_PROTO;
              end else begin
                head_d  = slot_of(slot_q, (CNT_W)'(1));
                held_d  = held_q - off_q - 1'b1;
                base_d  = item_q.index;
                bterm_d = item_q.term;
              end
            end
            clr_pkg::OP_START: begin
              if (64'(item_q.entry_count) > ~item_q.index) begin
                res.status = clr_pkg::ST_INVAL;
              end else if ((item_q.index == base_q && item_q.term == bterm_q) ||
                           (inr_q && ent.term == item_q.term)) begin
                res.matched = 1'b1;
                if (item_q.entry_count != '0) begin
                  phase_d = clr_pkg::PH_COMPARE;
                  rem_d   = item_q.entry_count;
                  acnt_d  = '0;
                  exp_d   = item_q.index + 64'd1;
                  roff_d  = (item_q.index == base_q) ? '0 : off_q + 1'b1;
                  protr_d = item_q.guard_index;
                  trunc_d = 1'b0;
                end
              end else if (item_q.index > last_q) begin
                res.result_index = last_q + 64'd1;
              end else if (!inr_q || off_q == '0) begin
                res.result_index = base_q + 64'd1;
              end else begin
                ct_d    = ent.term;
                woff_d  = off_q;
                wslot_d = slot_q;
                out_ld  = 1'b0;
                state_d = S_WREQ;
              end
            end
            clr_pkg::OP_ENTRY: begin
              if (phase_q == clr_pkg::PH_IDLE) begin
                res.status = clr_pkg::ST_PROTO;
              end else begin
                res.matched = 1'b1;
                if (item_q.index != exp_q || item_q.term == '0 || len_big) begin
                  res.status = clr_pkg::ST_INVAL;
                  phase_d = clr_pkg::PH_IDLE;
                end else if (item_q.cmd_ident == '0 && !item_q.config_ok) begin
                  res.status = clr_pkg::ST_PROTO;
                  phase_d = clr_pkg::PH_IDLE;
                end else begin
                  wr = (phase_q == clr_pkg::PH_WRITE);
                  if (phase_q == clr_pkg::PH_COMPARE) begin
                    if (exists_q && ent.term == item_q.term) begin
                      if (ent.cmd != item_q.cmd_ident || ent.len != item_q.byte_count ||
                          ent.tag != item_q.payload_tag) begin
                        res.status = clr_pkg::ST_PROTO;
                        phase_d = clr_pkg::PH_IDLE;
                      end else begin
                        rem_d  = rem_q - 1'b1;
                        exp_d  = exp_q + 64'd1;
                        roff_d = roff_q + 1'b1;
                        if (rem_q == 11'd1) begin
                          phase_d = clr_pkg::PH_IDLE;
                        end
                      end
                    end else if (exists_q && item_q.index <= protr_q) begin
                      res.status = clr_pkg::ST_PROTO;
                      phase_d = clr_pkg::PH_IDLE;
                    end else if (roff_q > cap || (CNT_W)'(rem_q) > cap - roff_q) begin
                      res.status = clr_pkg::ST_NOSPACE;
                      phase_d = clr_pkg::PH_IDLE;
                    end else begin
                      wr       = 1'b1;
                      wfrom_nx = item_q.index;
                      trunc_nx = exists_q;
                      wfrom_d  = wfrom_nx;
                      trunc_d  = trunc_nx;
                      phase_d  = clr_pkg::PH_WRITE;
                    end
                  end
                  if (wr) begin
                    ram_we  = 1'b1;
                    held_d  = roff_q + 1'b1;
                    last_d  = item_q.index;
                    lterm_d = item_q.term;
                    rem_d   = rem_q - 1'b1;
                    acnt_d  = acnt_q + 1'b1;
                    exp_d   = exp_q + 64'd1;
                    roff_d  = roff_q + 1'b1;
                    res.changed      = 1'b1;
                    res.result_index = wfrom_nx;
                    res.cut_index    = trunc_nx ? wfrom_nx : '0;
                    res.write_count  = acnt_q + 1'b1;
                    if (rem_q == 11'd1) begin
                      phase_d = clr_pkg::PH_IDLE;
                    end
                  end
                end
              end
            end
            clr_pkg::OP_READ: begin
              if (!inr_q) begin
                res.status = clr_pkg::ST_INVAL;
              end else begin
                res.result_index  = item_q.index;
                res.entry_term    = ent.term;
                res.entry_command = ent.cmd;
                res.entry_length  = ent.len;
                res.entry_tag     = ent.tag;
              end
            end
            default: begin
              res.status = clr_pkg::ST_INVAL;
            end
          endcase
        end
      end
      S_WREQ: begin
        ram_re    = 1'b1;
        ram_raddr = wslot_dec;
        state_d   = S_WCMP;
      end
      S_WCMP: begin
        fin = !eq || woff_q == (CNT_W)'(1);
        if (!fin || out_free) begin
          if (eq) begin
            woff_d  = woff_q - 1'b1;
            wslot_d = wslot_dec;
          end
          if (fin) begin
            out_ld = 1'b1;
            state_d = S_IDLE;
            res.result_index = base_q + 64'd1 + 64'(eq ? woff_q - 1'b1 : woff_q);
          end else begin
            state_d = S_WREQ;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    res.log_last_index = last_d;
    res.log_last_term  = lterm_d;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_IDX_MAX:   nm  = cfg_data_i[10:0];
        REG_IDX_SIDX:  nsi = cfg_data_i;
        REG_IDX_STERM: nst = cfg_data_i;
        default: ;
      endcase
      max_d   = nm;
      sidx_d  = nsi;
      sterm_d = nst;
      init_ok = (cfg_index_i <= REG_IDX_STERM) && ((nsi == '0) == (nst == '0)) &&
                (nm != '0) && (64'(nm) <= ~nsi);
      if (init_ok) begin
        base_d  = nsi;
        bterm_d = nst;
        last_d  = nsi;
        lterm_d = nst;
        held_d  = '0;
        head_d  = '0;
        phase_d = clr_pkg::PH_IDLE;
      end
    end

    out_valid_d = out_ld ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      max_q       <= clr_pkg::MaxEntriesReset;
      sidx_q      <= '0;
      sterm_q     <= '0;
      base_q      <= '0;
      bterm_q     <= '0;
      last_q      <= '0;
      lterm_q     <= '0;
      held_q      <= '0;
      head_q      <= '0;
      phase_q     <= clr_pkg::PH_IDLE;
      rem_q       <= '0;
      acnt_q      <= '0;
      exp_q       <= '0;
      protr_q     <= '0;
      wfrom_q     <= '0;
      roff_q      <= '0;
      trunc_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      max_q       <= max_d;
      sidx_q      <= sidx_d;
      sterm_q     <= sterm_d;
      base_q      <= base_d;
      bterm_q     <= bterm_d;
      last_q      <= last_d;
      lterm_q     <= lterm_d;
      held_q      <= held_d;
      head_q      <= head_d;
      phase_q     <= phase_d;
      rem_q       <= rem_d;
      acnt_q      <= acnt_d;
      exp_q       <= exp_d;
      protr_q     <= protr_d;
      wfrom_q     <= wfrom_d;
      roff_q      <= roff_d;
      trunc_q     <= trunc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q <= clr_pkg::item_t'(s_axis_tdata);
    end
    if (out_ld) begin
      out_q <= res;
    end
    off_q    <= off_d;
    slot_q   <= slot_d;
    inr_q    <= inr_d;
    exists_q <= exists_d;
    ct_q     <= ct_d;
    woff_q   <= woff_d;
    wslot_q  <= wslot_d;
  end

endmodule
`default_nettype wire

[sim/tb_consensus_log_reconciler.sv]
// Testbench for consensus_log_reconciler: drives mixed log operations and
// reconciliations over the request stream and checks each result against a mirror.
// Depends on clr_pkg and the consensus_log_reconciler top level.
`default_nettype none

class log_mirror;
  logic [63:0] term_mem [1024];
  logic [63:0] cmd_mem [1024];
  logic [63:0] tag_mem [1024];
  logic [12:0] len_mem [1024];
  logic [10:0] max_e = clr_pkg::MaxEntriesReset;
  logic [63:0] start_idx = '0;
  logic [63:0] start_trm = '0;
  logic [63:0] base_idx = '0;
  logic [63:0] base_trm = '0;
  int unsigned held = 0;
  logic [9:0]  head = '0;
  logic [1:0]  phase = clr_pkg::PH_IDLE;
  int unsigned pos = 0;
  int unsigned total = 0;
  logic [63:0] prev = '0;
  logic [63:0] protect = '0;
  bit          truncated = 0;
  clr_pkg::result_t answer_q[$];
  int errors = 0;

  function logic [9:0] slot(logic [63:0] off);
    return head + off[9:0];
  endfunction

  function logic [63:0] cap();
    return (max_e < 1024) ? 64'(max_e) : 64'd1024;
  endfunction

  function logic [63:0] last_idx();
    return base_idx + held;
  endfunction

  function logic [63:0] last_trm();
    return (held == 0) ? base_trm : term_mem[slot(held - 1)];
  endfunction

  function logic [63:0] term_at(logic [63:0] i);
    return term_mem[slot(i - base_idx - 1)];
  endfunction

  function bit held_at(logic [63:0] i);
    return i > base_idx && i <= last_idx();
  endfunction

  function void end_recon();
    phase = clr_pkg::PH_IDLE;
    pos = 0;
    total = 0;
    prev = '0;
    protect = '0;
    truncated = 0;
  endfunction

  function void configure(logic [1:0] r, logic [63:0] v);
    case (r)
      clr_pkg::REG_MAX_ENTRIES: max_e = v[10:0];
      clr_pkg::REG_START_INDEX: start_idx = v;
      clr_pkg::REG_START_TERM:  start_trm = v;
      default: return;
    endcase
    if (((start_idx == 0) != (start_trm == 0)) || max_e == 0 ||
        64'(max_e) > ~start_idx)
      return;
    base_idx = start_idx;
    base_trm = start_trm;
    held = 0;
    head = '0;
    end_recon();
  endfunction

  function void put(logic [63:0] off, clr_pkg::item_t it);
    logic [9:0] s;
    s = slot(off);
    term_mem[s] = it.term;
    cmd_mem[s] = it.cmd_ident;
    len_mem[s] = it.byte_count;
    tag_mem[s] = it.payload_tag;
  endfunction

  function void note_request(clr_pkg::item_t it);
    clr_pkg::result_t r;
    logic [63:0] nxt, off, rem, p, ct;
    logic [9:0] s;
    bit present;
    r = '0;
    if (it.operation != clr_pkg::OP_ENTRY && it.operation <= clr_pkg::OP_READ) end_recon();
    case (it.operation)
      clr_pkg::OP_APPEND: begin
        if (it.term == 0 || it.cmd_ident == 0) r.status = clr_pkg::ST_INVAL;
        else if (it.byte_count > 4096 || held >= cap() || last_idx() == '1)
          r.status = clr_pkg::ST_NOSPACE;
        else begin
          put(held, it);
          held++;
          r.result_index = last_idx();
        end
      end
      clr_pkg::OP_COMPACT: begin
        if (it.index <= base_idx || it.term == 0 || it.index > last_idx())
          r.status = clr_pkg::ST_INVAL;
        else if (term_at(it.index) != it.term) r.status = clr_pkg::ST_PROTO;
        else begin
          off = it.index - base_idx;
          head = slot(off);
          held -= 32'(off);
          base_idx = it.index;
          base_trm = it.term;
        end
      end
      clr_pkg::OP_START: begin
        if (64'(it.entry_count) > ~it.index) r.status = clr_pkg::ST_INVAL;
        else if (!((it.index == base_idx) ? (it.term == base_trm) :
                   (held_at(it.index) && term_at(it.index) == it.term))) begin
          if (it.index > last_idx()) r.result_index = last_idx() + 1;
          else if (it.index <= base_idx) r.result_index = base_idx + 1;
          else begin
            p = it.index;
            ct = term_at(p);
            while (p > base_idx + 1 && term_at(p - 1) == ct) p--;
            r.result_index = p;
          end
        end else begin
          r.matched = 1;
          if (it.entry_count != 0) begin
            phase = clr_pkg::PH_COMPARE;
            total = it.entry_count;
            prev = it.index;
            protect = it.guard_index;
          end
        end
      end
      clr_pkg::OP_ENTRY: begin
        if (phase == clr_pkg::PH_IDLE) r.status = clr_pkg::ST_PROTO;
        else begin
          nxt = prev + pos + 1;
          r.matched = 1;
          if (it.index != nxt || it.term == 0 || it.byte_count > 4096) begin
            r.status = clr_pkg::ST_INVAL;
            end_recon();
          end else if (it.cmd_ident == 0 && !it.config_ok) begin
            r.status = clr_pkg::ST_PROTO;
            end_recon();
          end else if (phase == clr_pkg::PH_COMPARE) begin
            off = nxt - base_idx - 1;
            present = off < held;
            s = slot(off);
            if (present && term_mem[s] == it.term) begin
              if (cmd_mem[s] != it.cmd_ident || len_mem[s] != it.byte_count ||
                  tag_mem[s] != it.payload_tag) begin
                r.status = clr_pkg::ST_PROTO;
                end_recon();
              end else begin
                pos++;
                if (pos >= total) end_recon();
              end
            end else begin
              rem = total - pos;
              if (present && nxt <= protect) begin
                r.status = clr_pkg::ST_PROTO;
                end_recon();
              end else if (off > cap() || rem > cap() - off) begin
                r.status = clr_pkg::ST_NOSPACE;
                end_recon();
              end else begin
                held = 32'(off);
                prev = nxt - 1;
                total = 32'(rem);
                pos = 0;
                truncated = present;
                phase = clr_pkg::PH_WRITE;
              end
            end
          end
          if (r.status == clr_pkg::ST_OK && phase == clr_pkg::PH_WRITE) begin
            put(held, it);
            held++;
            pos++;
            r.changed = 1;
            r.result_index = prev + 1;
            r.cut_index = truncated ? prev + 1 : '0;
            r.write_count = 11'(pos);
            if (pos >= total) end_recon();
          end
        end
      end
      clr_pkg::OP_READ: begin
        if (!held_at(it.index)) r.status = clr_pkg::ST_INVAL;
        else begin
          s = slot(it.index - base_idx - 1);
          r.result_index = it.index;
          r.entry_term = term_mem[s];
          r.entry_command = cmd_mem[s];
          r.entry_length = len_mem[s];
          r.entry_tag = tag_mem[s];
        end
      end
      default: r.status = clr_pkg::ST_INVAL;
    endcase
    r.log_last_index = last_idx();
    r.log_last_term = last_trm();
    answer_q.push_back(r);
  endfunction

  function void cmp(string f, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $error("%s expected %0h got %0h", f, e, a);
      errors++;
    end
  endfunction

  function void check_result(clr_pkg::result_t got);
    clr_pkg::result_t w;
    if (answer_q.size() == 0) begin
      $error("result with no request outstanding");
      errors++;
      return;
    end
    w = answer_q.pop_front();
    cmp("status", w.status, got.status);
    cmp("result_index", w.result_index, got.result_index);
    cmp("matched", w.matched, got.matched);
    cmp("changed", w.changed, got.changed);
    cmp("cut_index", w.cut_index, got.cut_index);
    cmp("write_count", w.write_count, got.write_count);
    cmp("entry_term", w.entry_term, got.entry_term);
    cmp("entry_command", w.entry_command, got.entry_command);
    cmp("entry_length", w.entry_length, got.entry_length);
    cmp("entry_tag", w.entry_tag, got.entry_tag);
    cmp("log_last_index", w.log_last_index, got.log_last_index);
    cmp("log_last_term", w.log_last_term, got.log_last_term);
  endfunction
endclass

module tb_consensus_log_reconciler;

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [351:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [479:0] m_axis_tdata;
  logic         cfg_valid_i = 0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i = '0;
  logic [63:0]  cfg_data_i = '0;

  log_mirror mirror = new();
  int idle_mode = 0;
  int sent = 0;

  consensus_log_reconciler dut (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #50000000;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    if (idle_mode == 2) m_axis_tready <= ($urandom_range(99) >= 80);
    else if (idle_mode == 3) m_axis_tready <= ($urandom_range(99) >= 7);
    else m_axis_tready <= 1'b1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) mirror.check_result(m_axis_tdata);
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_item(clr_pkg::item_t it);
    int gap, pct;
    gap = 0;
    pct = (idle_mode == 1) ? 80 : (idle_mode == 3) ? 7 : 0;
    while (gap < 60 && $urandom_range(99) < pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= it;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    mirror.note_request(it);
    sent++;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (mirror.answer_q.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] r, logic [63:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    mirror.configure(r, v);
    @(posedge clk_i);
  endtask

  function automatic clr_pkg::item_t mk(logic [2:0] op, logic [63:0] idx, logic [63:0] trm);
    clr_pkg::item_t it;
    it = '0;
    it.operation = op;
    it.index = idx;
    it.term = trm;
    it.cmd_ident = 64'($urandom_range(1, 1000));
    it.byte_count = 13'($urandom_range(0, 4096));
    it.payload_tag = rand64();
    return it;
  endfunction

  function automatic logic [63:0] next_term();
    logic [63:0] t;
    t = mirror.last_trm() + $urandom_range(0, 1);
    return (t == 0) ? 64'd1 : t;
  endfunction

  task automatic send_append();
    clr_pkg::item_t it;
    it = mk(clr_pkg::OP_APPEND, rand64(), next_term());
    case ($urandom_range(19))
      0: it.term = '0;
      1: it.cmd_ident = '0;
      2: it.byte_count = 13'($urandom_range(4097, 8191));
      3: it.cmd_ident = rand64();
      default: ;
    endcase
    send_item(it);
  endtask

  task automatic send_compact();
    clr_pkg::item_t it;
    logic [63:0] i;
    i = mirror.base_idx + $urandom_range(1, (mirror.held > 0) ? mirror.held : 1);
    it = mk(clr_pkg::OP_COMPACT, i, mirror.held_at(i) ? mirror.term_at(i) : 64'd1);
    if ($urandom_range(9) == 0) it.term = it.term + 1;
    if ($urandom_range(19) == 0) it.index = mirror.base_idx;
    send_item(it);
  endtask

  task automatic send_read();
    clr_pkg::item_t it;
    it = mk(clr_pkg::OP_READ, mirror.base_idx + $urandom_range(0, mirror.held + 1), '0);
    send_item(it);
  endtask

  task automatic send_noise();
    clr_pkg::item_t it;
    it = {4'b0, 11'($urandom), rand64(), 1'($urandom), rand64(), 13'($urandom),
          rand64(), rand64(), rand64(), 3'($urandom)};
    if ($urandom_range(1) == 0) it.operation = 3'($urandom_range(5, 7));
    send_item(it);
  endtask

  task automatic send_reconcile();
    clr_pkg::item_t it, cur;
    logic [63:0] p, t, lt;
    int cnt;
    bit copying;
    if ($urandom_range(9) < 8) begin
      p = mirror.base_idx + $urandom_range(0, mirror.held);
      t = (p == mirror.base_idx) ? mirror.base_trm : mirror.term_at(p);
    end else begin
      p = mirror.base_idx + $urandom_range(0, mirror.held + 3);
      t = 64'($urandom_range(0, 6));
    end
    cnt = ($urandom_range(9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
    it = mk(clr_pkg::OP_START, p, t);
    it.entry_count = 11'(cnt);
    it.guard_index = ($urandom_range(1) == 0) ? mirror.base_idx :
                     mirror.base_idx + $urandom_range(0, mirror.held + 2);
    send_item(it);
    copying = 1;
    lt = (t == 0) ? 64'd1 : t;
    for (int k = 1; k <= cnt; k++) begin
      if (mirror.phase == clr_pkg::PH_IDLE && $urandom_range(9) < 7) break;
      cur = mk(clr_pkg::OP_ENTRY, p + k, lt);
      if (copying && mirror.held_at(p + k) && $urandom_range(9) < 6) begin
        cur = mk(clr_pkg::OP_READ, p + k, '0);
        cur.operation = clr_pkg::OP_ENTRY;
        cur.term = mirror.term_at(p + k);
        cur.cmd_ident = mirror.cmd_mem[mirror.slot(p + k - mirror.base_idx - 1)];
        cur.byte_count = mirror.len_mem[mirror.slot(p + k - mirror.base_idx - 1)];
        cur.payload_tag = mirror.tag_mem[mirror.slot(p + k - mirror.base_idx - 1)];
      end else begin
        copying = 0;
        cur.term = lt + $urandom_range(0, 1);
        if (mirror.held_at(p + k) && mirror.term_at(p + k) == cur.term) cur.term++;
      end
      lt = cur.term;
      case ($urandom_range(29))
        0: cur.index = cur.index + 1;
        1: cur.term = '0;
        2: cur.byte_count = 13'($urandom_range(4097, 8191));
        3: begin cur.cmd_ident = '0; cur.config_ok = 1'($urandom); end
        4: cur.payload_tag = ~cur.payload_tag;
        default: ;
      endcase
      send_item(cur);
    end
  endtask

  task automatic run_random(int n);
    int stop;
    stop = sent + n;
    while (sent < stop) begin
      if ((sent % 170) == 0) settle();
      if (mirror.held + 12 > mirror.cap() && $urandom_range(1) == 0) send_compact();
      else case ($urandom_range(19))
        0, 1, 2, 3, 4:  send_append();
        5, 6:           send_compact();
        7, 8, 9:        send_read();
        10:             send_noise();
        default:        send_reconcile();
      endcase
    end
  endtask

  task automatic run_directed();
    clr_pkg::item_t it;
    send_item(mk(clr_pkg::OP_READ, '0, '0));
    send_item(mk(clr_pkg::OP_APPEND, 64'd1, '0));
    it = mk(clr_pkg::OP_APPEND, 64'd1, 64'd1);
    it.cmd_ident = '0;
    send_item(it);
    it = mk(clr_pkg::OP_APPEND, 64'd1, 64'd1);
    it.byte_count = 13'd4097;
    send_item(it);
    send_item(mk(clr_pkg::OP_APPEND, '0, 64'd1));
    send_item(mk(clr_pkg::OP_APPEND, '0, 64'd1));
    repeat (3) send_item(mk(clr_pkg::OP_APPEND, '0, 64'd2));
    send_item(mk(clr_pkg::OP_START, 64'd5, 64'd3));
    send_item(mk(clr_pkg::OP_START, 64'd9, 64'd3));
    it = mk(clr_pkg::OP_START, '1, 64'd1);
    it.entry_count = 11'd1;
    send_item(it);
    send_item(mk(clr_pkg::OP_ENTRY, 64'd1, 64'd1));
    for (int op = 5; op <= 7; op++) send_item(mk(3'(op), '0, '0));
    send_item(mk(clr_pkg::OP_COMPACT, '0, 64'd1));
    send_item(mk(clr_pkg::OP_COMPACT, 64'd2, 64'd9));
    send_item(mk(clr_pkg::OP_COMPACT, 64'd1, 64'd1));
    send_item(mk(clr_pkg::OP_READ, 64'd3, '0));
    it = mk(clr_pkg::OP_START, 64'd3, 64'd2);
    it.entry_count = 11'd3;
    send_item(it);
    it = mk(clr_pkg::OP_ENTRY, 64'd4, 64'd2);
    it.cmd_ident = mirror.cmd_mem[mirror.slot(2)];
    it.byte_count = mirror.len_mem[mirror.slot(2)];
    it.payload_tag = mirror.tag_mem[mirror.slot(2)];
    send_item(it);
    send_item(mk(clr_pkg::OP_ENTRY, 64'd5, 64'd3));
    send_item(mk(clr_pkg::OP_ENTRY, 64'd6, 64'd3));
    send_item(mk(clr_pkg::OP_START, 64'd6, 64'd3));
    it = mk(clr_pkg::OP_APPEND, '1, '1);
    it.cmd_ident = '1;
    it.byte_count = 13'd4096;
    it.payload_tag = '1;
    send_item(it);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    idle_mode = 0;
    run_directed();
    run_random(330);

    settle();
    write_reg(clr_pkg::REG_MAX_ENTRIES, 64'd8);
    idle_mode = 1;
    run_random(300);

    settle();
    write_reg(clr_pkg::REG_START_INDEX, 64'hFFFF_FFFF_FFFF_FFF7);
    write_reg(clr_pkg::REG_START_TERM, '1);
    idle_mode = 2;
    run_random(300);

    settle();
    write_reg(clr_pkg::REG_MAX_ENTRIES, '0);
    write_reg(clr_pkg::REG_MAX_ENTRIES, 64'd2047);
    write_reg(clr_pkg::REG_START_INDEX, '0);
    write_reg(clr_pkg::REG_START_TERM, '0);
    idle_mode = 3;
    run_random(400);

    settle();
    write_reg(clr_pkg::REG_MAX_ENTRIES, 64'd1);
    idle_mode = 0;
    run_random(150);

    settle();
    write_reg(clr_pkg::REG_MAX_ENTRIES, 64'd1024);
    write_reg(clr_pkg::REG_START_INDEX, {32'b0, $urandom});
    write_reg(clr_pkg::REG_START_TERM, rand64() | 64'd1);
    idle_mode = 2;
    run_random(170);
    idle_mode = 1;
    run_random(170);

    settle();
    repeat (20) @(posedge clk_i);
    if (mirror.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

`default_nettype wire

[filelist.f]
hdl/clr_pkg.sv
hdl/clr_ram.sv
hdl/consensus_log_reconciler.sv
sim/tb_consensus_log_reconciler.sv
